// File: rtl/core/lpdf_pkg.sv
// types and constants shared by the length prefix deframer
`default_nettype none

package lpdf_pkg;

    localparam int unsigned MAX_HDR_BYTES = 8;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LENGTH   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_REJECT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_HEADER_BYTES = 2'd0,
        CFG_BIG_ENDIAN   = 2'd1,
        CFG_RX_CAPACITY  = 2'd2,
        CFG_DISCARD      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  hdr_cnt;
        logic [63:0] len_acc;
        logic [63:0] remaining;
    } t_state;

    typedef struct packed {
        logic [3:0]  header_bytes;
        logic        big_endian;
        logic [31:0] rx_capacity;
        logic        discard;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [63:0] message_length;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/lpdf_step.sv
// per-item next state and result logic of the deframer
`default_nettype none

module lpdf_step (
    input  var lpdf_pkg::t_state  i_state,
    input  var lpdf_pkg::t_cfg    i_cfg,
    input  wire logic [7:0]       i_data_byte,
    output lpdf_pkg::t_state      o_state,
    output logic                  o_res_valid,
    output lpdf_pkg::t_result     o_res
);

    logic [3:0]  hdr_eff;
    logic [3:0]  cnt_inc;
    logic [63:0] acc_new;
    logic [63:0] rem_dec;
    logic        oversize;

    // header size clamped into 1..max
    always_comb begin
        if (i_cfg.header_bytes == 4'd0) begin
            hdr_eff = 4'd1;
        end else if (i_cfg.header_bytes > 4'(lpdf_pkg::MAX_HDR_BYTES)) begin
            hdr_eff = 4'(lpdf_pkg::MAX_HDR_BYTES);
        end else begin
            hdr_eff = i_cfg.header_bytes;
        end
    end

    assign cnt_inc = i_state.hdr_cnt + 4'd1;

    always_comb begin
        if (i_cfg.big_endian) begin
            acc_new = {i_state.len_acc[55:0], i_data_byte};
        end else begin
            acc_new = i_state.len_acc
                    | (64'(i_data_byte) << {i_state.hdr_cnt[2:0], 3'b000});
        end
    end

    assign rem_dec  = (i_state.remaining != 64'd0) ? i_state.remaining - 64'd1
                                                   : i_state.remaining;
    assign oversize = !i_cfg.discard
                    && ((acc_new[63:32] != 32'd0) || (acc_new[31:0] > i_cfg.rx_capacity));

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (i_state.phase)
            lpdf_pkg::PH_ERROR: begin
                o_res_valid = 1'b1;
                o_res.kind  = lpdf_pkg::KIND_REJECT;
            end
            lpdf_pkg::PH_PAYLOAD: begin
                o_state.remaining = rem_dec;
                if (rem_dec == 64'd0) begin
                    o_state.phase = lpdf_pkg::PH_HEADER;
                end
                if (!i_cfg.discard) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = lpdf_pkg::KIND_PAYLOAD;
                    o_res.payload_byte = i_data_byte;
                    o_res.last         = (rem_dec == 64'd0);
                end
            end
            lpdf_pkg::PH_HEADER: begin
                o_state.len_acc = acc_new;
                o_state.hdr_cnt = cnt_inc;
                if (cnt_inc >= hdr_eff) begin
                    o_state.hdr_cnt      = 4'd0;
                    o_state.len_acc      = 64'd0;
                    o_res_valid          = 1'b1;
                    o_res.message_length = acc_new;
                    if (oversize) begin
                        o_state.phase     = lpdf_pkg::PH_ERROR;
                        o_state.remaining = 64'd0;
                        o_res.kind        = lpdf_pkg::KIND_OVERSIZE;
                    end else begin
                        o_state.remaining = acc_new;
                        o_state.phase     = (acc_new == 64'd0) ? lpdf_pkg::PH_HEADER
                                                               : lpdf_pkg::PH_PAYLOAD;
                        o_res.kind        = lpdf_pkg::KIND_LENGTH;
                        o_res.last        = (acc_new == 64'd0);
                    end
                end
            end
            default: begin
                o_state.phase = lpdf_pkg::PH_HEADER;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/length_prefix_deframer.sv
// top level of the length prefix deframer
//
// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_ready    i_data_byte
// output   out        o_out_valid / i_out_ready  o_kind, o_payload_byte,
//                                                o_message_length, o_last_of_message
// config   in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; each item is registered
// in the input register, and an item that gives a result then moves to the output register
// the 64-bit length shift and the 64-bit remaining-count decrement set the path
// synchronous active-low reset returns to header phase with default config
// a stalled output holds its item while the input register keeps its own
`default_nettype none

module length_prefix_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [63:0]      o_message_length,
    output logic             o_last_of_message,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    lpdf_pkg::t_cfg    r_cfg;
    lpdf_pkg::t_state  r_state;
    lpdf_pkg::t_state  n_state;
    lpdf_pkg::t_result n_out;
    lpdf_pkg::t_result r_out;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic              res_valid;
    logic              out_free;
    logic              advance;

    lpdf_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_data_byte (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (n_out)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // item leaves the input register when it needs no output slot or one is free
    assign advance    = r_in_valid && (!res_valid || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_bytes <= 4'd1;
            r_cfg.big_endian   <= 1'b1;
            r_cfg.rx_capacity  <= 32'hFFFF_FFFF;
            r_cfg.discard      <= 1'b0;
        end else if (i_cfg_we) begin
            case (lpdf_pkg::t_cfg_idx'(i_cfg_idx))
                lpdf_pkg::CFG_HEADER_BYTES: r_cfg.header_bytes <= i_cfg_data[3:0];
                lpdf_pkg::CFG_BIG_ENDIAN:   r_cfg.big_endian   <= i_cfg_data[0];
                lpdf_pkg::CFG_RX_CAPACITY:  r_cfg.rx_capacity  <= i_cfg_data;
                lpdf_pkg::CFG_DISCARD:      r_cfg.discard      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= lpdf_pkg::PH_HEADER;
            r_state.hdr_cnt   <= 4'd0;
            r_state.len_acc   <= 64'd0;
            r_state.remaining <= 64'd0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance && res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_message_length  = r_out.message_length;
    assign o_last_of_message = r_out.last;

`ifndef ASSERT_OFF
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == lpdf_pkg::PH_ERROR |=> r_state.phase == lpdf_pkg::PH_ERROR)
        else $error("error phase left without reset");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == lpdf_pkg::PH_PAYLOAD |-> r_state.remaining != 64'd0)
        else $error("payload phase with nothing remaining");

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hdr_cnt < 4'(lpdf_pkg::MAX_HDR_BYTES))
        else $error("header count past maximum header size");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lpdf_pkg::KIND_REJECT
        |-> o_message_length == 64'd0 && o_payload_byte == 8'd0 && !o_last_of_message)
        else $error("rejected item carries data");
`endif

endmodule

`default_nettype wire

// File: dv/tb_length_prefix_deframer.sv
// self-checking testbench for the length prefix deframer
module tb_length_prefix_deframer;

    localparam int IDLE_GAP     = 4;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;
    localparam int MSGS_PER_SET = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [63:0] o_message_length;
    logic        o_last_of_message;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_data  = '0;

    // predictor copy of the block
    lpdf_pkg::t_cfg   cfg;
    lpdf_pkg::t_phase rx_phase;
    logic [3:0]       rx_hdr_cnt;
    logic [63:0]      rx_len_acc;
    logic [63:0]      rx_remaining;

    lpdf_pkg::t_result due_results[$];
    logic [7:0]        pending_bytes[$];
    bit                offering      = 1'b0;
    int                errors        = 0;
    int                cycles        = 0;
    int                queued        = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_reqs     = 0;
    int                hold_done     = 0;
    int                hold_left     = 0;

    length_prefix_deframer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_message_length  (o_message_length),
        .o_last_of_message (o_last_of_message),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned header_len();
        if (cfg.header_bytes == 4'd0) return 1;
        if (cfg.header_bytes > lpdf_pkg::MAX_HDR_BYTES) return lpdf_pkg::MAX_HDR_BYTES;
        return cfg.header_bytes;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output lpdf_pkg::t_result res);
        logic [63:0] len;
        res = '0;
        res.kind = lpdf_pkg::KIND_REJECT;
        case (rx_phase)
            lpdf_pkg::PH_ERROR: begin
                return 1'b1;
            end
            lpdf_pkg::PH_PAYLOAD: begin
                if (rx_remaining != 64'd0) rx_remaining--;
                if (rx_remaining == 64'd0) rx_phase = lpdf_pkg::PH_HEADER;
                if (cfg.discard) return 1'b0;
                res.kind         = lpdf_pkg::KIND_PAYLOAD;
                res.payload_byte = b;
                res.last         = (rx_remaining == 64'd0);
                return 1'b1;
            end
            default: begin
                // each byte placed by the byte order in force when it arrives
                if (cfg.big_endian) rx_len_acc = {rx_len_acc[55:0], b};
                else rx_len_acc |= 64'(b) << (8 * rx_hdr_cnt[2:0]);
                rx_hdr_cnt++;
                if (rx_hdr_cnt < header_len()) return 1'b0;
                len        = rx_len_acc;
                rx_hdr_cnt = '0;
                rx_len_acc = '0;
                res.message_length = len;
                if (!cfg.discard && len > {32'd0, cfg.rx_capacity}) begin
                    rx_phase     = lpdf_pkg::PH_ERROR;
                    rx_remaining = '0;
                    res.kind     = lpdf_pkg::KIND_OVERSIZE;
                    return 1'b1;
                end
                rx_remaining = len;
                rx_phase     = (len == 64'd0) ? lpdf_pkg::PH_HEADER : lpdf_pkg::PH_PAYLOAD;
                res.kind     = lpdf_pkg::KIND_LENGTH;
                res.last     = (len == 64'd0);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // sender: offers queued bytes, predicts each accepted item
    always @(posedge i_clk) begin : drive_bytes
        lpdf_pkg::t_result res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (deframe_byte(i_data_byte, res)) due_results.push_back(res);
                offering = 1'b0;
            end
            if (!offering) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data_byte <= pending_bytes.pop_front();
                    i_in_valid  <= 1'b1;
                    offering = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_done != hold_reqs) begin
            hold_done   <= hold_reqs;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        lpdf_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind %0d length %0h",
                                          o_kind, o_message_length));
            end else begin
                want = due_results.pop_front();
                check_field("kind", 64'(o_kind), 64'(want.kind));
                check_field("payload_byte", 64'(o_payload_byte), 64'(want.payload_byte));
                check_field("message_length", o_message_length, want.message_length);
                check_field("last_of_message", 64'(o_last_of_message), 64'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || offering || due_results.size() != 0)
            @(posedge i_clk);
        // bytes that give no item may still be inside the block
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input lpdf_pkg::t_cfg_idx idx, input logic [31:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lpdf_pkg::CFG_HEADER_BYTES: cfg.header_bytes = val[3:0];
            lpdf_pkg::CFG_BIG_ENDIAN:   cfg.big_endian   = val[0];
            lpdf_pkg::CFG_RX_CAPACITY:  cfg.rx_capacity  = val;
            default:                    cfg.discard      = val[0];
        endcase
    endtask

    task automatic push_seq(input logic [63:0] seq, input int count);
        for (int i = count - 1; i >= 0; i--) pending_bytes.push_back(seq[8*i +: 8]);
        queued += count;
    endtask

    task automatic push_payload(input int count);
        for (int i = 0; i < count; i++) pending_bytes.push_back(8'($urandom()));
        queued += count;
    endtask

    // header in the current byte order, then sent payload bytes
    task automatic push_message(input logic [63:0] len, input int sent);
        int unsigned n;
        n = header_len();
        for (int unsigned i = 0; i < n; i++) begin
            if (cfg.big_endian) pending_bytes.push_back(8'(len >> (8 * (n - 1 - i))));
            else pending_bytes.push_back(8'(len >> (8 * i)));
        end
        queued += n;
        push_payload(sent);
    endtask

    // finish a message left cut short before a settings change
    task automatic settle_payload();
        wait_idle();
        if (rx_phase == lpdf_pkg::PH_PAYLOAD) push_payload(int'(rx_remaining));
    endtask

    function automatic int unsigned pick_length();
        int unsigned lim;
        lim = ($urandom_range(9) == 0) ? 255 : (cfg.discard ? 48 : 24);
        if (!cfg.discard && cfg.rx_capacity < lim) lim = cfg.rx_capacity;
        return $urandom_range(lim);
    endfunction

    task automatic randomize_config();
        logic [31:0] junk;
        junk = $urandom();
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, {junk[31:4], 4'($urandom_range(15))});
        junk = $urandom();
        write_reg(lpdf_pkg::CFG_BIG_ENDIAN, {junk[31:1], 1'($urandom_range(1))});
        case ($urandom_range(3))
            0:       write_reg(lpdf_pkg::CFG_RX_CAPACITY, 32'd0);
            1:       write_reg(lpdf_pkg::CFG_RX_CAPACITY, $urandom_range(40));
            2:       write_reg(lpdf_pkg::CFG_RX_CAPACITY, 32'hFFFF_FFFF);
            default: write_reg(lpdf_pkg::CFG_RX_CAPACITY, $urandom());
        endcase
        junk = $urandom();
        write_reg(lpdf_pkg::CFG_DISCARD, {junk[31:1], 1'($urandom_range(3) == 0)});
    endtask

    task automatic run_random(input int target);
        int          stop_at;
        int unsigned len;
        stop_at = queued + target;
        while (queued < stop_at) begin
            randomize_config();
            settle_payload();
            for (int m = 0; m < MSGS_PER_SET && queued < stop_at; m++) begin
                len = pick_length();
                if (m == MSGS_PER_SET - 1 && len > 1 && $urandom_range(2) == 0)
                    push_message(len, $urandom_range(len - 1, 1));
                else
                    push_message(len, len);
            end
        end
    endtask

    initial begin
        cfg          = '{4'd1, 1'b1, 32'hFFFF_FFFF, 1'b0};
        rx_phase     = lpdf_pkg::PH_HEADER;
        rx_hdr_cnt   = '0;
        rx_len_acc   = '0;
        rx_remaining = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 52;
        // defaults after reset: one byte headers, msb first
        push_seq(64'h00, 1);
        push_seq(64'h02_AA55, 3);
        // header size zero acts as one, length equal to the capacity
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, 32'd0);
        write_reg(lpdf_pkg::CFG_RX_CAPACITY, 32'd3);
        push_seq(64'h03_00FF80, 4);
        // discard mode: over capacity is still announced, payload dropped
        write_reg(lpdf_pkg::CFG_DISCARD, 32'd1);
        push_seq(64'h04_11223344, 5);
        // discard switched off in the middle of a payload
        push_seq(64'h02_5A, 2);
        write_reg(lpdf_pkg::CFG_DISCARD, 32'd0);
        push_seq(64'hC3, 1);
        // header size shrunk in the middle of a header
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, 32'd4);
        push_seq(64'h000000, 3);
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, 32'd2);
        push_seq(64'h01_7E, 2);
        // byte order switched in the middle of a header
        write_reg(lpdf_pkg::CFG_BIG_ENDIAN, 32'd0);
        push_seq(64'h00, 1);
        write_reg(lpdf_pkg::CFG_BIG_ENDIAN, 32'd1);
        push_seq(64'h02_3CE7, 3);

        run_random(333);
        send_idle_pct = 52;
        recv_idle_pct = 36;
        run_random(333);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(334);

        // long receiver hold while the sender keeps a long message coming
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, 32'd1);
        write_reg(lpdf_pkg::CFG_BIG_ENDIAN, 32'd1);
        write_reg(lpdf_pkg::CFG_RX_CAPACITY, 32'hFFFF_FFFF);
        write_reg(lpdf_pkg::CFG_DISCARD, 32'd0);
        settle_payload();
        hold_reqs++;
        push_message(200, 200);

        // oversize ends the run: the error phase lasts until reset
        write_reg(lpdf_pkg::CFG_RX_CAPACITY, 32'd100);
        write_reg(lpdf_pkg::CFG_HEADER_BYTES, 32'd15);
        settle_payload();
        push_seq(64'hFFFF_FFFF_FFFF_FFFF, 8);
        push_payload(6);

        wait_idle();
        repeat (IDLE_GAP) @(posedge i_clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: length_prefix_deframer.f
rtl/core/lpdf_pkg.sv
rtl/core/lpdf_step.sv
rtl/core/length_prefix_deframer.sv
dv/tb_length_prefix_deframer.sv
